// ===== design/sorted_deadline_timer_queue_assert.svh =====
// Assertion macros for the sorted deadline timer queue.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, off while in reset
`define SDTQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdtq: check failed");

// Next-cycle implication, off while in reset
`define SDTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdtq: check failed");

`endif

// ===== design/sdtq_pkg.sv =====
// Shared types, constants and helper functions of the sorted deadline timer queue.
// No dependencies; used by sdtq_cell and the top level.
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 16;
    localparam int TIME_BITS = 32;
    localparam int MAX_OUT   = 16;
    localparam int CNT_BITS  = $clog2(MAX_OUT + 1);
    localparam int CMP_BITS  = (ID_BITS > 16) ? ID_BITS : 16;
    localparam int KEY_BITS  = (TIME_BITS > 20) ? TIME_BITS : 20;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] KIND_ADD_OK   = 3'd0;
    localparam logic [2:0] KIND_ADD_FULL = 3'd1;
    localparam logic [2:0] KIND_CANCEL   = 3'd2;
    localparam logic [2:0] KIND_EXPIRED  = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] interval;
        logic [15:0] cancel_id;
    } request_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] handle;
        logic        success;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ADD,
        CMD_CANCEL,
        CMD_POP,
        CMD_DEC,
        CMD_CLEAR
    } cell_cmd_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cell_cmd_t             cmd;
        logic [TIME_BITS-1:0]  key;
        logic [ID_BITS-1:0]    new_id;
        logic [15:0]           cancel_id;
    } cell_ctl_t;

    // rem is the distance from now to the deadline
    typedef struct packed {
        logic                  valid;
        logic [TIME_BITS-1:0]  rem;
        logic [ID_BITS-1:0]    id;
        logic                  cancelled;
    } cell_data_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK
    } state_t;

    function automatic logic [TIME_BITS-1:0] interval_key(input logic [19:0] interval);
        logic [KEY_BITS-1:0] wide;
        wide = KEY_BITS'(interval);
        return wide[TIME_BITS-1:0];
    endfunction

    function automatic logic [15:0] id_out(input logic [ID_BITS-1:0] id);
        logic [CMP_BITS-1:0] wide;
        wide = CMP_BITS'(id);
        return wide[15:0];
    endfunction

    function automatic logic id_match(input logic [ID_BITS-1:0] id,
                                      input logic [15:0] cid);
        logic [CMP_BITS-1:0] a;
        logic [CMP_BITS-1:0] b;
        a = CMP_BITS'(id);
        b = CMP_BITS'(cid);
        return a == b;
    endfunction

endpackage

// ===== design/sdtq_cell.sv =====
// One slot of the sorted timer chain: holds a timer and trades it with its neighbors.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps

module sdtq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sdtq_pkg::cell_ctl_t ctl,
    input  sdtq_pkg::cell_data_t left_data,
    input  sdtq_pkg::cell_data_t right_data,
    input  logic                left_r,
    input  logic                seen_in,
    output sdtq_pkg::cell_data_t data,
    output logic                r_out,
    output logic                seen_out
);

    logic                          valid_reg, valid_next;
    logic [sdtq_pkg::TIME_BITS-1:0] rem_reg, rem_next;
    logic [sdtq_pkg::ID_BITS-1:0]   id_reg, id_next;
    logic                          canc_reg, canc_next;
    logic                          match;

    assign data.valid     = valid_reg;
    assign data.rem       = rem_reg;
    assign data.id        = id_reg;
    assign data.cancelled = canc_reg;

    // At or behind the insert point: empty, or deadline not earlier than the new one
    assign r_out    = !valid_reg || (rem_reg >= ctl.key);
    assign match    = valid_reg && sdtq_pkg::id_match(id_reg, ctl.cancel_id);
    assign seen_out = seen_in || match;

    always_comb
    begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        id_next    = id_reg;
        canc_next  = canc_reg;
        unique case (ctl.cmd)
            sdtq_pkg::CMD_ADD:
            begin
                if (left_r)
                begin
                    valid_next = left_data.valid;
                    rem_next   = left_data.rem;
                    id_next    = left_data.id;
                    canc_next  = left_data.cancelled;
                end
                else if (r_out)
                begin
                    valid_next = 1'b1;
                    rem_next   = ctl.key;
                    id_next    = ctl.new_id;
                    canc_next  = 1'b0;
                end
            end
            sdtq_pkg::CMD_CANCEL:
            begin
                if (match && !seen_in)
                    canc_next = 1'b1;
            end
            sdtq_pkg::CMD_POP:
            begin
                valid_next = right_data.valid;
                rem_next   = right_data.rem;
                id_next    = right_data.id;
                canc_next  = right_data.cancelled;
            end
            sdtq_pkg::CMD_DEC:
            begin
                rem_next = rem_reg - 1'b1;
            end
            sdtq_pkg::CMD_CLEAR:
            begin
                valid_next = 1'b0;
                canc_next  = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        id_reg   <= id_next;
        canc_reg <= canc_next;
    end

endmodule

// ===== design/sorted_deadline_timer_queue.sv =====
// Top level of the sorted deadline timer queue: command FSM, id counter and the cell chain.
// Depends on sdtq_pkg, sdtq_cell and sorted_deadline_timer_queue_assert.svh.
//
//   channel   ports                      handshake
//   -------   ------------------------   -------------------------------------
//   request   start, busy, request       taken at an edge with start=1, busy=0
//   result    result_valid, result       each result valid for a single cycle, no back-pressure
//
// Add, cancel and clear pass through the execute state before the next acceptance;
// the single result appears in the same cycle as the updated chain.
// In a tick the chain pops one head entry per cycle while the head is due, then
// ages every entry in a final step.
// Reset empties the queue and zeroes the id counter; no clearing pass is needed.
`timescale 1ns / 1ps

`include "sorted_deadline_timer_queue_assert.svh"

module sorted_deadline_timer_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sdtq_pkg::request_t request,
    output logic               result_valid,
    output sdtq_pkg::result_t  result
);

    sdtq_pkg::state_t               state_reg, state_next;
    sdtq_pkg::request_t             req_reg, req_next;
    logic [sdtq_pkg::ID_BITS-1:0]   last_id_reg, last_id_next;
    logic                           res_valid_reg, res_valid_next;
    sdtq_pkg::result_t              res_reg, res_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [15:0]                    pend_id_reg, pend_id_next;
    logic [sdtq_pkg::CNT_BITS-1:0]  exp_cnt_reg, exp_cnt_next;

    sdtq_pkg::cell_ctl_t  ctl;
    sdtq_pkg::cell_data_t cell_q [sdtq_pkg::DEPTH];
    logic                 r_chain [sdtq_pkg::DEPTH];
    logic                 seen_chain [sdtq_pkg::DEPTH];

    logic accept;
    logic full;
    logic found;
    logic pop_hit;
    logic report;

    assign accept       = start && !busy;
    assign busy         = (state_reg != sdtq_pkg::ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign full    = cell_q[sdtq_pkg::DEPTH-1].valid;
    assign found   = seen_chain[sdtq_pkg::DEPTH-1];
    assign pop_hit = cell_q[0].valid && (cell_q[0].rem[sdtq_pkg::TIME_BITS-1:1] == '0);
    assign report  = !cell_q[0].cancelled &&
                     (exp_cnt_reg < sdtq_pkg::CNT_BITS'(sdtq_pkg::MAX_OUT));

    for (genvar i = 0; i < sdtq_pkg::DEPTH; i++)
    begin : g_cell
        sdtq_pkg::cell_data_t left_d;
        sdtq_pkg::cell_data_t right_d;
        logic                 left_r;
        logic                 seen_in;

        if (i == 0)
        begin : g_head
            assign left_d  = '0;
            assign left_r  = 1'b0;
            assign seen_in = 1'b0;
        end
        else
        begin : g_body
            assign left_d  = cell_q[i-1];
            assign left_r  = r_chain[i-1];
            assign seen_in = seen_chain[i-1];
        end

        if (i == sdtq_pkg::DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = cell_q[i+1];
        end

        sdtq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .left_r     (left_r),
            .seen_in    (seen_in),
            .data       (cell_q[i]),
            .r_out      (r_chain[i]),
            .seen_out   (seen_chain[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        last_id_next    = last_id_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        exp_cnt_next    = exp_cnt_reg;
        ctl.cmd         = sdtq_pkg::CMD_HOLD;
        ctl.key         = sdtq_pkg::interval_key(req_reg.interval);
        ctl.new_id      = last_id_reg + 1'b1;
        ctl.cancel_id   = req_reg.cancel_id;

        unique case (state_reg)
            sdtq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next        = request;
                    pend_valid_next = 1'b0;
                    exp_cnt_next    = '0;
                    state_next      = (request.op == sdtq_pkg::OP_TICK) ?
                                      sdtq_pkg::ST_TICK : sdtq_pkg::ST_EXEC;
                end
            end
            sdtq_pkg::ST_EXEC:
            begin
                res_valid_next = 1'b1;
                state_next     = sdtq_pkg::ST_IDLE;
                unique case (req_reg.op)
                    sdtq_pkg::OP_ADD:
                    begin
                        if (full)
                            res_next = '{sdtq_pkg::KIND_ADD_FULL, 16'd0, 1'b0, 1'b1};
                        else
                        begin
                            ctl.cmd      = sdtq_pkg::CMD_ADD;
                            last_id_next = ctl.new_id;
                            res_next     = '{sdtq_pkg::KIND_ADD_OK,
                                             sdtq_pkg::id_out(ctl.new_id), 1'b1, 1'b1};
                        end
                    end
                    sdtq_pkg::OP_CANCEL:
                    begin
                        ctl.cmd  = sdtq_pkg::CMD_CANCEL;
                        res_next = '{sdtq_pkg::KIND_CANCEL, 16'd0, found, 1'b1};
                    end
                    sdtq_pkg::OP_CLEAR:
                    begin
                        ctl.cmd  = sdtq_pkg::CMD_CLEAR;
                        res_next = '{sdtq_pkg::KIND_DONE, 16'd0, 1'b1, 1'b1};
                    end
                    default:
                    begin
                        // tick never lands here
                        res_next = '{sdtq_pkg::KIND_DONE, 16'd0, 1'b1, 1'b1};
                    end
                endcase
            end
            sdtq_pkg::ST_TICK:
            begin
                if (pop_hit)
                begin
                    ctl.cmd = sdtq_pkg::CMD_POP;
                    if (report)
                    begin
                        // hold the newest expiry back until it is known to be the final one
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_next = '{sdtq_pkg::KIND_EXPIRED, pend_id_reg, 1'b1, 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = sdtq_pkg::id_out(cell_q[0].id);
                        exp_cnt_next    = exp_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    ctl.cmd         = sdtq_pkg::CMD_DEC;
                    res_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = sdtq_pkg::ST_IDLE;
                    if (pend_valid_reg)
                        res_next = '{sdtq_pkg::KIND_EXPIRED, pend_id_reg, 1'b1, 1'b1};
                    else
                        res_next = '{sdtq_pkg::KIND_DONE, 16'd0, 1'b1, 1'b1};
                end
            end
            default:
            begin
                state_next = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sdtq_pkg::ST_IDLE;
            last_id_reg    <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            exp_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_id_reg    <= last_id_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
            exp_cnt_reg    <= exp_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        pend_id_reg <= pend_id_next;
    end

    `SDTQ_ASSERT_NEXT(a_accept_busy, accept, busy)
    `SDTQ_ASSERT_NOW(a_more_pending, result_valid && !result.last, busy)
    `SDTQ_ASSERT_NEXT(a_tick_ends, (state_reg == sdtq_pkg::ST_TICK) && !pop_hit,
                      result_valid && result.last && !busy)
    `SDTQ_ASSERT_NOW(a_packed_chain, !cell_q[0].valid, !cell_q[sdtq_pkg::DEPTH-1].valid)

endmodule
